### rtl/brrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brrd_pkg
// shared types, constants and helpers of the bilevel row run decoder
// ----------------------------------------------------------------------------
package brrd_pkg;

    localparam int MAX_ROW_PIXELS = 4096;
    localparam int WORD_PIXELS    = 64;
    localparam int POS_W          = $clog2(MAX_ROW_PIXELS) + 1;   // 0..MAX_ROW_PIXELS
    localparam int WORD_SHIFT     = $clog2(WORD_PIXELS);
    localparam int NW_W           = POS_W - WORD_SHIFT;           // word counts
    localparam int IDX_W          = 6;
    localparam int LEN_W          = WORD_SHIFT + 1;               // 0..WORD_PIXELS
    localparam int BYTE_W         = 8;
    localparam int FIELD_W        = 32;
    localparam int RUNS_W         = 30;
    localparam int HDR_SHORT_LEN_BIT = 31;
    localparam int HDR_SHORT_GAP_BIT = 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CLIP,
        ST_GAP,
        ST_RUN,
        ST_FILL,
        ST_LAST
    } state_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_GAP,
        PH_LEN
    } phase_t;

    typedef enum logic [1:0] {
        TGT_START,
        TGT_END,
        TGT_WIDTH
    } adv_tgt_t;

    typedef struct packed {
        logic     take;        // byte accepted this cycle
        logic     sum_start;   // position plus gap
        logic     sum_end;     // run start/end targets, clip check
        logic     adv_en;      // walk position toward target
        logic     adv_set;     // set pixels passed over
        adv_tgt_t adv_tgt;
        logic     emit_last;   // send final word, restart row
    } dp_cmd_t;

    typedef struct packed {
        logic zero_hdr;   // this byte ends a header with no runs
        logic len_done;   // this byte ends a length field
        logic adv_idle;   // position has reached target
        logic runs_zero;  // no runs left
        logic out_free;   // output register can take a beat
    } dp_stat_t;

    // ones in bits below k, k in 0..WORD_PIXELS
    function automatic logic [WORD_PIXELS-1:0] low_mask(input logic [LEN_W-1:0] k);
        logic [WORD_PIXELS-1:0] m;
        if (k >= LEN_W'(WORD_PIXELS)) begin
            m = '1;
        end else begin
            m = ({{(WORD_PIXELS-1){1'b0}}, 1'b1} << k) - {{(WORD_PIXELS-1){1'b0}}, 1'b1};
        end
        return m;
    endfunction

endpackage

### rtl/brrd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brrd_ctrl
// sequencer: byte intake, run target setup, word walking and row finish
// ----------------------------------------------------------------------------
module brrd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brrd_pkg::dp_stat_t stat,
    output brrd_pkg::dp_cmd_t  cmd
);

    brrd_pkg::state_t state_reg;
    brrd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brrd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            brrd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (stat.zero_hdr) begin
                        state_next = brrd_pkg::ST_FILL;
                    end else if (stat.len_done) begin
                        state_next = brrd_pkg::ST_SUM;
                    end
                end
            end
            brrd_pkg::ST_SUM:  state_next = brrd_pkg::ST_CLIP;
            brrd_pkg::ST_CLIP: state_next = brrd_pkg::ST_GAP;
            brrd_pkg::ST_GAP: begin
                if (stat.adv_idle) begin
                    state_next = brrd_pkg::ST_RUN;
                end
            end
            brrd_pkg::ST_RUN: begin
                if (stat.adv_idle) begin
                    state_next = stat.runs_zero ? brrd_pkg::ST_FILL : brrd_pkg::ST_IDLE;
                end
            end
            brrd_pkg::ST_FILL: begin
                if (stat.adv_idle) begin
                    state_next = brrd_pkg::ST_LAST;
                end
            end
            brrd_pkg::ST_LAST: begin
                if (stat.out_free) begin
                    state_next = brrd_pkg::ST_IDLE;
                end
            end
            default: state_next = brrd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd         = '0;
        cmd.adv_tgt = brrd_pkg::TGT_WIDTH;
        s_ready     = 1'b0;
        unique case (state_reg)
            brrd_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            brrd_pkg::ST_SUM:  cmd.sum_start = 1'b1;
            brrd_pkg::ST_CLIP: cmd.sum_end   = 1'b1;
            brrd_pkg::ST_GAP: begin
                cmd.adv_en  = 1'b1;
                cmd.adv_tgt = brrd_pkg::TGT_START;
            end
            brrd_pkg::ST_RUN: begin
                cmd.adv_en  = 1'b1;
                cmd.adv_set = 1'b1;
                cmd.adv_tgt = brrd_pkg::TGT_END;
            end
            brrd_pkg::ST_FILL: begin
                cmd.adv_en  = 1'b1;
                cmd.adv_tgt = brrd_pkg::TGT_WIDTH;
            end
            brrd_pkg::ST_LAST: cmd.emit_last = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/brrd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brrd_dp
// datapath: field assembly, run arithmetic, word builder and output register
// ----------------------------------------------------------------------------
module brrd_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [brrd_pkg::POS_W-1:0]            cfg_wr_data,
    input  logic [brrd_pkg::BYTE_W-1:0]           s_data_byte,
    input  brrd_pkg::dp_cmd_t                     cmd,
    output brrd_pkg::dp_stat_t                    stat,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [brrd_pkg::WORD_PIXELS-1:0]      m_pixel_word,
    output logic [brrd_pkg::IDX_W-1:0]            m_word_index,
    output logic                                  m_last_word,
    output logic                                  m_overflow_error
);

    localparam int PW = brrd_pkg::POS_W;
    localparam int FW = brrd_pkg::FIELD_W;
    localparam int WP = brrd_pkg::WORD_PIXELS;
    localparam int WS = brrd_pkg::WORD_SHIFT;
    localparam int NW = brrd_pkg::NW_W;
    localparam int RW = brrd_pkg::RUNS_W;

    // control state
    logic [PW-1:0]     row_width_reg;
    brrd_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]        byte_count_reg, byte_count_next;
    logic [FW-1:0]     field_accum_reg, field_accum_next;
    logic              short_len_reg, short_len_next;
    logic              short_gap_reg, short_gap_next;
    logic [RW-1:0]     runs_left_reg, runs_left_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [WP-1:0]     partial_reg, partial_next;
    logic              clip_reg, clip_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [FW-1:0]     gap_reg, gap_next;
    logic [FW-1:0]     len_reg, len_next;
    logic [FW:0]       sum_reg, sum_next;
    logic [PW-1:0]     start_reg, start_next;
    logic [PW-1:0]     end_reg, end_next;
    logic [WP-1:0]     out_word_reg, out_word_next;
    logic [brrd_pkg::IDX_W-1:0] out_idx_reg, out_idx_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    // combinational
    logic [PW-1:0]     width_eff;
    logic [PW-1:0]     width_rnd;
    logic [NW-1:0]     nwords;
    logic [PW-1:0]     pos_eff;
    logic [4:0]        shift_amt;
    logic [FW-1:0]     field_val;
    logic [1:0]        byte_inc;
    logic [1:0]        field_len;
    logic              is_hdr;
    logic              field_done;
    logic [FW+1:0]     end_sum;
    logic [PW-1:0]     target;
    logic              adv_idle;
    logic [NW-1:0]     word_num;
    logic [NW-1:0]     word_inc;
    logic [PW-1:0]     base;
    logic [PW-1:0]     base_end;
    logic              last_w;
    logic [PW-1:0]     wend;
    logic [PW-1:0]     seg;
    logic [PW-1:0]     rel;
    logic [WP-1:0]     set_mask;
    logic [WP-1:0]     step_word;
    logic              step_emit;
    logic              out_free;
    logic              step_go;
    logic              last_go;

    function automatic logic [brrd_pkg::IDX_W-1:0] word_num_last(input logic [NW-1:0] n);
        logic [NW-1:0] t;
        t = n - NW'(1);
        return t[brrd_pkg::IDX_W-1:0];
    endfunction

    // width clamp and word count
    always_comb begin
        if (row_width_reg == '0) begin
            width_eff = PW'(1);
        end else if (row_width_reg > PW'(brrd_pkg::MAX_ROW_PIXELS)) begin
            width_eff = PW'(brrd_pkg::MAX_ROW_PIXELS);
        end else begin
            width_eff = row_width_reg;
        end
        width_rnd = width_eff + PW'(WP - 1);
        nwords    = width_rnd[PW-1:WS];
        pos_eff   = (pos_reg > width_eff) ? width_eff : pos_reg;
    end

    // field assembly, little endian
    always_comb begin
        shift_amt = {byte_count_reg, 3'b000};
        field_val = field_accum_reg | ({{(FW-brrd_pkg::BYTE_W){1'b0}}, s_data_byte} << shift_amt);
        byte_inc  = byte_count_reg + 2'd1;
        is_hdr    = (phase_reg != brrd_pkg::PH_GAP) && (phase_reg != brrd_pkg::PH_LEN);
        if (phase_reg == brrd_pkg::PH_GAP) begin
            field_len = short_gap_reg ? 2'd2 : 2'd0;
        end else if (phase_reg == brrd_pkg::PH_LEN) begin
            field_len = short_len_reg ? 2'd2 : 2'd0;
        end else begin
            field_len = 2'd0;
        end
        field_done = (byte_inc == field_len);
    end

    // one word-bounded step of the position walk
    always_comb begin
        unique case (cmd.adv_tgt)
            brrd_pkg::TGT_START: target = start_reg;
            brrd_pkg::TGT_END:   target = end_reg;
            default:             target = width_eff;
        endcase
        adv_idle  = (pos_eff >= target);
        word_num  = pos_eff[PW-1:WS];
        word_inc  = word_num + NW'(1);
        base      = {word_num, {WS{1'b0}}};
        base_end  = base + PW'(WP);
        last_w    = (word_inc >= nwords);
        wend      = last_w ? width_eff : base_end;
        seg       = (target < wend) ? target : wend;
        rel       = seg - base;
        set_mask  = brrd_pkg::low_mask(rel[WS:0])
                  & ~brrd_pkg::low_mask({1'b0, pos_eff[WS-1:0]});
        step_word = partial_reg | (cmd.adv_set ? set_mask : '0);
        step_emit = !last_w && (seg == base_end);
        out_free  = !out_valid_reg || m_ready;
        step_go   = cmd.adv_en && !adv_idle && (!step_emit || out_free);
        last_go   = cmd.emit_last && out_free;
        end_sum   = {1'b0, sum_reg} + {2'b00, len_reg};
    end

    always_comb begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        field_accum_next = field_accum_reg;
        short_len_next   = short_len_reg;
        short_gap_next   = short_gap_reg;
        runs_left_next   = runs_left_reg;
        gap_next         = gap_reg;
        len_next         = len_reg;
        sum_next         = sum_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        clip_next        = clip_reg;
        pos_next         = pos_reg;
        partial_next     = partial_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_word_next    = out_word_reg;
        out_idx_next     = out_idx_reg;
        out_last_next    = out_last_reg;
        out_ovf_next     = out_ovf_reg;

        if (cmd.take) begin
            // a narrower width pulls the position in on every byte
            pos_next = pos_eff;
            if (field_done) begin
                byte_count_next  = '0;
                field_accum_next = '0;
                if (is_hdr) begin
                    short_len_next = field_val[brrd_pkg::HDR_SHORT_LEN_BIT];
                    short_gap_next = field_val[brrd_pkg::HDR_SHORT_GAP_BIT];
                    runs_left_next = field_val[RW-1:0];
                    phase_next     = brrd_pkg::PH_GAP;
                end else if (phase_reg == brrd_pkg::PH_GAP) begin
                    gap_next   = field_val;
                    phase_next = brrd_pkg::PH_LEN;
                end else begin
                    len_next   = field_val;
                    phase_next = brrd_pkg::PH_GAP;
                end
            end else begin
                byte_count_next  = byte_inc;
                field_accum_next = field_val;
            end
        end

        if (cmd.sum_start) begin
            sum_next = {{(FW+1-PW){1'b0}}, pos_eff} + {1'b0, gap_reg};
        end

        if (cmd.sum_end) begin
            start_next = (sum_reg > (FW+1)'(width_eff)) ? width_eff : sum_reg[PW-1:0];
            end_next   = (end_sum > (FW+2)'(width_eff)) ? width_eff : end_sum[PW-1:0];
            if ((len_reg != '0) && (end_sum > (FW+2)'(width_eff))) begin
                clip_next = 1'b1;
            end
            runs_left_next = runs_left_reg - RW'(1);
        end

        if (step_go) begin
            pos_next = seg;
            if (step_emit) begin
                partial_next   = '0;
                out_valid_next = 1'b1;
                out_word_next  = step_word;
                out_idx_next   = word_num[brrd_pkg::IDX_W-1:0];
                out_last_next  = 1'b0;
                out_ovf_next   = 1'b0;
            end else begin
                partial_next = step_word;
            end
        end

        if (last_go) begin
            out_valid_next = 1'b1;
            out_word_next  = partial_reg;
            out_idx_next   = word_num_last(nwords);
            out_last_next  = 1'b1;
            out_ovf_next   = clip_reg;
            pos_next       = '0;
            partial_next   = '0;
            clip_next      = 1'b0;
            phase_next     = brrd_pkg::PH_HEADER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg   <= PW'(brrd_pkg::MAX_ROW_PIXELS);
            phase_reg       <= brrd_pkg::PH_HEADER;
            byte_count_reg  <= '0;
            field_accum_reg <= '0;
            short_len_reg   <= 1'b0;
            short_gap_reg   <= 1'b0;
            runs_left_reg   <= '0;
            pos_reg         <= '0;
            partial_reg     <= '0;
            clip_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                row_width_reg <= cfg_wr_data;
            end
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            field_accum_reg <= field_accum_next;
            short_len_reg   <= short_len_next;
            short_gap_reg   <= short_gap_next;
            runs_left_reg   <= runs_left_next;
            pos_reg         <= pos_next;
            partial_reg     <= partial_next;
            clip_reg        <= clip_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gap_reg      <= gap_next;
        len_reg      <= len_next;
        sum_reg      <= sum_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb begin
        stat.zero_hdr  = field_done && is_hdr && (field_val[RW-1:0] == '0);
        stat.len_done  = field_done && (phase_reg == brrd_pkg::PH_LEN);
        stat.adv_idle  = adv_idle;
        stat.runs_zero = (runs_left_reg == '0);
        stat.out_free  = out_free;
    end

    assign m_valid          = out_valid_reg;
    assign m_pixel_word     = out_word_reg;
    assign m_word_index     = out_idx_reg;
    assign m_last_word      = out_last_reg;
    assign m_overflow_error = out_ovf_reg;

endmodule

### rtl/bilevel_row_run_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilevel_row_run_decoder_top
// rebuilds one bilevel image row from its run-length record as 64-pixel words
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+-------------------------
//  input    | s_valid s_ready s_data_byte             | one record byte
//  result   | m_valid m_ready m_pixel_word            | one packed row word
//           | m_word_index m_last_word                |
//           | m_overflow_error                        |
//  config   | cfg_wr_en cfg_wr_data                   | row width, no handshake
//
//  a byte that closes a length field leads the sequencer through the sum and
//  clip steps, the gap walk and the run walk, where the position walker
//  makes one word-bounded step per cycle unless a stalled result holds it;
//  the row end adds the zero fill and the last word
//  a stalled result holds the walker on steps that complete a word and on the last word
//  aresetn is synchronous, active low; row width resets to 4096
//
module bilevel_row_run_decoder_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [brrd_pkg::POS_W-1:0]             cfg_wr_data,
    // record bytes in
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [brrd_pkg::BYTE_W-1:0]            s_data_byte,
    // row words out
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [brrd_pkg::WORD_PIXELS-1:0]       m_pixel_word,
    output logic [brrd_pkg::IDX_W-1:0]             m_word_index,
    output logic                                   m_last_word,
    output logic                                   m_overflow_error
);

    // commands from sequencer, status back from datapath
    brrd_pkg::dp_cmd_t  cmd;
    brrd_pkg::dp_stat_t stat;

    // sequencer: takes bytes only when idle, steps through run setup and walk
    brrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: field assembly, run targets, word builder, output register
    brrd_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_data_byte      (s_data_byte),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_word     (m_pixel_word),
        .m_word_index     (m_word_index),
        .m_last_word      (m_last_word),
        .m_overflow_error (m_overflow_error)
    );

`ifndef SYNTHESIS
    // overflow only reported on the closing word of a row
    a_ovf_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_overflow_error || m_last_word))
        else $error("overflow flag on a non-final word");

    // a stalled beat stays put until it is taken
    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_pixel_word) && $stable(m_word_index) &&
             $stable(m_last_word) && $stable(m_overflow_error)))
        else $error("result beat changed while stalled");

    // bytes are only taken while no run walk or row finish is pending
    a_no_take_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.adv_en || cmd.emit_last || cmd.sum_start || cmd.sum_end) |-> !s_ready)
        else $error("byte taken while the walker is busy");
`endif

endmodule
